// ===== hdl/vt4_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared constants and item codes for the 4x4 fixed-point vertex transform.
// ----------------------------------------------------------------------------
package vt4_pkg;

   localparam int WORD_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // Matrix dimension: four rows, four columns, one lane per row.
   localparam int DIM       = 4;
   localparam int DIM_WIDTH = $clog2(DIM);

   typedef enum logic [0:0] {
      MODE_LOAD      = 1'b0,
      MODE_TRANSFORM = 1'b1
   } mode_type;

endpackage

// ===== hdl/vt4_req_if.sv =====
// ----------------------------------------------------------------------------
// Vertex transform request channel
// Carries load and transform transactions into the block.
// ----------------------------------------------------------------------------
interface vt4_req_if #(
   parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [0:0]                    mode;
   logic [vt4_pkg::DIM_WIDTH-1:0] row_index;
   logic [vt4_pkg::DIM_WIDTH-1:0] col_index;
   logic signed [WORD_WIDTH-1:0]  load_value;
   logic signed [WORD_WIDTH-1:0]  in_x;
   logic signed [WORD_WIDTH-1:0]  in_y;
   logic signed [WORD_WIDTH-1:0]  in_z;
   logic signed [WORD_WIDTH-1:0]  in_w;

   modport source (
      output valid, mode, row_index, col_index, load_value, in_x, in_y, in_z, in_w,
      input  ready
   );

   modport sink (
      input  valid, mode, row_index, col_index, load_value, in_x, in_y, in_z, in_w,
      output ready
   );
endinterface

// ===== hdl/vt4_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Vertex transform response channel
// Carries the transformed vector and the saturation flag out of the block.
// ----------------------------------------------------------------------------
interface vt4_rsp_if #(
   parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [WORD_WIDTH-1:0] out_x;
   logic signed [WORD_WIDTH-1:0] out_y;
   logic signed [WORD_WIDTH-1:0] out_z;
   logic signed [WORD_WIDTH-1:0] out_w;
   logic                         saturated;

   modport source (
      output valid, out_x, out_y, out_z, out_w, saturated,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z, out_w, saturated,
      output ready
   );
endinterface

// ===== hdl/vt4_matrix.sv =====
// ----------------------------------------------------------------------------
// Vertex transform matrix store
// Sixteen signed words, row-major, cleared at reset, one element per write.
// ----------------------------------------------------------------------------
module vt4_matrix #(
   parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [vt4_pkg::DIM_WIDTH-1:0] wr_row,
   input  logic [vt4_pkg::DIM_WIDTH-1:0] wr_col,
   input  logic signed [WORD_WIDTH-1:0]  wr_data,
   output logic signed [WORD_WIDTH-1:0]  elem [vt4_pkg::DIM][vt4_pkg::DIM]
);

   logic signed [WORD_WIDTH-1:0] elem_ff [vt4_pkg::DIM][vt4_pkg::DIM];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < vt4_pkg::DIM; r++) begin
            for (int c = 0; c < vt4_pkg::DIM; c++) begin
               elem_ff[r][c] <= '0;
            end
         end
      end else if (wr_en) begin
         elem_ff[wr_row][wr_col] <= wr_data;
      end
   end

   assign elem = elem_ff;

endmodule

// ===== hdl/vt4_lane.sv =====
// ----------------------------------------------------------------------------
// Vertex transform row lane
// Multiplies one matrix row by the vector, registers the scaled products,
// then sums and saturates them to one output word.
// ----------------------------------------------------------------------------
module vt4_lane #(
   parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [WORD_WIDTH-1:0] row_elem [vt4_pkg::DIM],
   input  logic signed [WORD_WIDTH-1:0] vec      [vt4_pkg::DIM],
   output logic signed [WORD_WIDTH-1:0] dot_word,
   output logic                         dot_clip
);

   localparam int FULL_W = 2 * WORD_WIDTH;
   localparam int PROD_W = FULL_W - FRAC_BITS;
   localparam int SUM_W  = PROD_W + vt4_pkg::DIM_WIDTH;
   localparam int TOP_W  = SUM_W - WORD_WIDTH + 1;

   logic signed [FULL_W-1:0] full_prod [vt4_pkg::DIM];
   logic signed [PROD_W-1:0] prod_in   [vt4_pkg::DIM];
   logic signed [PROD_W-1:0] prod_ff   [vt4_pkg::DIM];
   logic signed [SUM_W-1:0]  sum;
   logic [TOP_W-1:0]         sum_top;
   logic                     fits;

   // Dropping the low fraction bits is an arithmetic shift toward minus infinity.
   always_comb begin
      for (int j = 0; j < vt4_pkg::DIM; j++) begin
         full_prod[j] = row_elem[j] * vec[j];
         prod_in[j]   = full_prod[j][FULL_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      sum = '0;
      for (int j = 0; j < vt4_pkg::DIM; j++) begin
         sum = sum + SUM_W'(prod_ff[j]);
      end
   end

   // The sum fits when every bit above the word's sign bit matches it.
   assign sum_top = sum[SUM_W-1:WORD_WIDTH-1];
   assign fits    = (&sum_top) | ~(|sum_top);

   always_comb begin
      if (fits) begin
         dot_word = sum[WORD_WIDTH-1:0];
      end else if (sum[SUM_W-1]) begin
         dot_word = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      end else begin
         dot_word = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      end
   end

   assign dot_clip = ~fits;

endmodule

// ===== hdl/vt4_merge.sv =====
// ----------------------------------------------------------------------------
// Vertex transform merge stage
// Gathers the four lane words and clip flags into the response register.
// ----------------------------------------------------------------------------
module vt4_merge #(
   parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [WORD_WIDTH-1:0] lane_word [vt4_pkg::DIM],
   input  logic                         lane_clip [vt4_pkg::DIM],
   vt4_rsp_if.source                    rsp_ch
);

   logic                         valid_ff;
   logic                         valid_in;
   logic                         load;
   logic                         any_clip;
   logic signed [WORD_WIDTH-1:0] word_ff [vt4_pkg::DIM];
   logic                         sat_ff;

   assign in_ready = ~valid_ff | rsp_ch.ready;
   assign load     = in_valid & in_ready;

   always_comb begin
      any_clip = 1'b0;
      for (int i = 0; i < vt4_pkg::DIM; i++) begin
         any_clip = any_clip | lane_clip[i];
      end
   end

   always_comb begin
      if (in_ready) begin
         valid_in = in_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= lane_word;
         sat_ff  <= any_clip;
      end
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_x     = word_ff[0];
   assign rsp_ch.out_y     = word_ff[1];
   assign rsp_ch.out_z     = word_ff[2];
   assign rsp_ch.out_w     = word_ff[3];
   assign rsp_ch.saturated = sat_ff;

endmodule

// ===== hdl/vertex_transform_4x4_top.sv =====
// ----------------------------------------------------------------------------
// Vertex transform 4x4 top level
// Fixed-point 4x4 matrix times homogeneous vector with a loadable matrix.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless a held response
// stalls the request side. A load transaction writes one matrix element at
// the accepting edge and produces no response; a transform transaction
// produces one response through the product and response registers, and
// later transactions see every earlier load. Four row lanes each multiply
// their row by the vector, register the scaled products, then sum and
// saturate them; the merge stage holds the response. Each pipeline stage has
// its own valid bit, so new requests keep flowing into empty stages while a
// finished response waits to be taken. The matrix is zero after reset.
module vertex_transform_4x4_top #(
   parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   vt4_req_if.sink   req_ch,
   vt4_rsp_if.source rsp_ch
);

   logic                         req_accept;
   logic                         req_load;
   logic                         req_xform;
   logic                         prod_valid_ff;
   logic                         prod_valid_in;
   logic                         merge_ready;
   logic signed [WORD_WIDTH-1:0] elem      [vt4_pkg::DIM][vt4_pkg::DIM];
   logic signed [WORD_WIDTH-1:0] vec       [vt4_pkg::DIM];
   logic signed [WORD_WIDTH-1:0] lane_word [vt4_pkg::DIM];
   logic                         lane_clip [vt4_pkg::DIM];

   assign req_ch.ready = ~prod_valid_ff | merge_ready;
   assign req_accept   = req_ch.valid & req_ch.ready;
   assign req_load     = req_accept & (req_ch.mode == vt4_pkg::MODE_LOAD);
   assign req_xform    = req_accept & (req_ch.mode == vt4_pkg::MODE_TRANSFORM);

   assign vec[0] = req_ch.in_x;
   assign vec[1] = req_ch.in_y;
   assign vec[2] = req_ch.in_z;
   assign vec[3] = req_ch.in_w;

   // When ready is high the product stage either was empty or hands off now.
   always_comb begin
      if (req_ch.ready) begin
         prod_valid_in = req_xform;
      end else begin
         prod_valid_in = prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   vt4_matrix #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_matrix (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_load),
      .wr_row  (req_ch.row_index),
      .wr_col  (req_ch.col_index),
      .wr_data (req_ch.load_value),
      .elem    (elem)
   );

   for (genvar i = 0; i < vt4_pkg::DIM; i++) begin : g_lane
      vt4_lane #(
         .WORD_WIDTH (WORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .load     (req_xform),
         .row_elem (elem[i]),
         .vec      (vec),
         .dot_word (lane_word[i]),
         .dot_clip (lane_clip[i])
      );
   end

   vt4_merge #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid_ff),
      .in_ready  (merge_ready),
      .lane_word (lane_word),
      .lane_clip (lane_clip),
      .rsp_ch    (rsp_ch)
   );

   // An empty product stage never blocks the request side.
   a_ready_when_empty : assert property (
      @(posedge clock) disable iff (reset) !prod_valid_ff |-> req_ch.ready
   ) else $error("request stalled with an empty product stage");

   // A transform transaction always occupies the product stage next cycle.
   a_xform_enters : assert property (
      @(posedge clock) disable iff (reset) req_xform |=> prod_valid_ff
   ) else $error("accepted transform did not reach the product stage");

   // A load transaction never creates a pipeline entry.
   a_load_no_entry : assert property (
      @(posedge clock) disable iff (reset) req_load |=> !prod_valid_ff
   ) else $error("load transaction created a pipeline entry");

   // A stalled product stage keeps its transaction.
   a_stall_holds : assert property (
      @(posedge clock) disable iff (reset)
      (prod_valid_ff && !merge_ready) |=> prod_valid_ff
   ) else $error("stalled product stage lost its transaction");

   // A load lands in the addressed matrix element.
   a_load_written : assert property (
      @(posedge clock) disable iff (reset)
      req_load |=> elem[$past(req_ch.row_index)][$past(req_ch.col_index)]
                   == $past(req_ch.load_value)
   ) else $error("matrix element not written by load transaction");

endmodule
